/* rtl/core/iqws_pkg.sv */
// Package for the issue queue wakeup/select block.
// Request and status codes, queue constants, request and result payloads. No dependencies.
package iqws_pkg;
	typedef enum logic [1:0] {
		REQ_DISPATCH = 2'd0,
		REQ_WAKEUP   = 2'd1,
		REQ_SELECT   = 2'd2,
		REQ_REMOVE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_BAD_IDX = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	localparam int unsigned IQ_DEPTH    = 12;
	localparam int unsigned IQ_TAG_BITS = 6;
	localparam int unsigned DATA_BITS   = 32;
	localparam int unsigned UNIT_BITS   = 3;
	localparam int unsigned IDX_BITS    = 4;

	typedef struct packed {
		logic do_dispatch;
		logic do_wakeup;
		logic do_remove;
		logic do_select;
	} iqws_cmd_t;

	typedef struct packed {
		req_t                         req_type;
		logic [IDX_BITS-1:0]          slot_index;
		logic                         issue_enable;
		logic [UNIT_BITS-1:0]         unit_type;
		logic signed [DATA_BITS-1:0]  literal_value;
		logic                         a_ready;
		logic [IQ_TAG_BITS-1:0]       a_tag;
		logic signed [DATA_BITS-1:0]  a_value;
		logic                         b_ready;
		logic [IQ_TAG_BITS-1:0]       b_tag;
		logic signed [DATA_BITS-1:0]  b_value;
		logic [IQ_TAG_BITS-1:0]       dest_tag;
	} iqws_req_t;

	typedef struct packed {
		status_t                      status_code;
		logic [IDX_BITS-1:0]          picked_index;
		logic signed [DATA_BITS-1:0]  picked_literal;
		logic signed [DATA_BITS-1:0]  picked_a_value;
		logic signed [DATA_BITS-1:0]  picked_b_value;
		logic [IQ_TAG_BITS-1:0]       picked_dest;
		logic [IDX_BITS-1:0]          occupancy;
		logic                         queue_empty;
		logic                         queue_full;
	} iqws_rsp_t;
endpackage

/* rtl/core/iqws_stream_if.sv */
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
interface iqws_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/iqws_datapath.sv */
// Entry storage, collapse shift, wakeup compare and oldest-ready select.
// Depends on iqws_pkg.
module iqws_datapath #(
	parameter int unsigned QUEUE_DEPTH = 12,
	parameter int unsigned TAG_BITS    = 6,
	parameter int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1),
	parameter int unsigned IW          = $clog2(QUEUE_DEPTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iqws_pkg::iqws_cmd_t            cmd,
	input  logic [IW-1:0]                  rm_idx,
	input  logic                           in_en,
	input  logic [iqws_pkg::UNIT_BITS-1:0] in_unit,
	input  logic [31:0]                    in_lit,
	input  logic                           in_ar,
	input  logic [TAG_BITS-1:0]            in_at,
	input  logic [31:0]                    in_av,
	input  logic                           in_br,
	input  logic [TAG_BITS-1:0]            in_bt,
	input  logic [31:0]                    in_bv,
	input  logic [TAG_BITS-1:0]            in_dest,
	output logic [CNT_BITS-1:0]            count,
	output logic                           hit,
	output logic [IW-1:0]                  hit_idx,
	output logic [31:0]                    hit_lit,
	output logic [31:0]                    hit_av,
	output logic [31:0]                    hit_bv,
	output logic [TAG_BITS-1:0]            hit_dest
);
	import iqws_pkg::*;

	logic [QUEUE_DEPTH-1:0]          en_q, ar_q, br_q;
	logic [UNIT_BITS-1:0]            unit_q [QUEUE_DEPTH];
	logic [31:0]                     lit_q [QUEUE_DEPTH];
	logic [31:0]                     av_q [QUEUE_DEPTH];
	logic [31:0]                     bv_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]             at_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]             bt_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]             dest_q [QUEUE_DEPTH];
	logic [CNT_BITS-1:0]             count_q;
	logic [QUEUE_DEPTH-1:0]          qual;

	assign count = count_q;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			qual[i] = (CNT_BITS'(i) < count_q) && en_q[i] && ar_q[i] && br_q[i]
				&& (unit_q[i] == in_unit);
		end
	end

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (qual[i]) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
			end
		end
		hit_lit  = lit_q[hit_idx];
		hit_av   = av_q[hit_idx];
		hit_bv   = bv_q[hit_idx];
		hit_dest = dest_q[hit_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.do_dispatch) begin
			count_q <= count_q + CNT_BITS'(1);
		end else if (cmd.do_remove) begin
			count_q <= count_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cmd.do_dispatch && CNT_BITS'(i) == count_q) begin
				en_q[i]   <= in_en;
				unit_q[i] <= in_unit;
				lit_q[i]  <= in_lit;
				ar_q[i]   <= in_ar;
				at_q[i]   <= in_at;
				av_q[i]   <= in_av;
				br_q[i]   <= in_br;
				bt_q[i]   <= in_bt;
				bv_q[i]   <= in_bv;
				dest_q[i] <= in_dest;
			end else if (cmd.do_wakeup && CNT_BITS'(i) < count_q) begin
				if (at_q[i] == in_at) begin
					ar_q[i] <= 1'b1;
					av_q[i] <= in_av;
				end
				if (bt_q[i] == in_at) begin
					br_q[i] <= 1'b1;
					bv_q[i] <= in_av;
				end
			end else if (cmd.do_remove && IW'(i) >= rm_idx && i + 1 < QUEUE_DEPTH) begin
				en_q[i]   <= en_q[i+1];
				unit_q[i] <= unit_q[i+1];
				lit_q[i]  <= lit_q[i+1];
				ar_q[i]   <= ar_q[i+1];
				at_q[i]   <= at_q[i+1];
				av_q[i]   <= av_q[i+1];
				br_q[i]   <= br_q[i+1];
				bt_q[i]   <= bt_q[i+1];
				bv_q[i]   <= bv_q[i+1];
				dest_q[i] <= dest_q[i+1];
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("occupancy above depth");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.do_dispatch |=> count_q != '0)
		else $error("dispatch left queue empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.do_dispatch, cmd.do_wakeup, cmd.do_remove}) <= 1)
		else $error("conflicting commands");
endmodule

/* rtl/core/iqws_ctrl.sv */
// Controller: decodes requests, checks bounds, owns the result valid flag.
// Depends on iqws_pkg.
module iqws_ctrl #(
	parameter int unsigned QUEUE_DEPTH = 12,
	parameter int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  iqws_pkg::req_t                req,
	input  logic [iqws_pkg::IDX_BITS-1:0] idx,
	input  logic [CNT_BITS-1:0]           count,
	input  logic                          hit,
	output iqws_pkg::iqws_cmd_t           cmd,
	output iqws_pkg::status_t             status,
	output logic                          load,
	output logic                          out_valid,
	input  logic                          out_ready
);
	import iqws_pkg::*;

	logic acc, full;
	logic out_valid_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign acc       = in_valid && in_ready;
	assign load      = acc;
	assign out_valid = out_valid_q;
	assign full      = count == CNT_BITS'(QUEUE_DEPTH);

	always_comb begin
		cmd    = '0;
		status = ST_OK;
		unique case (req)
			REQ_DISPATCH: begin
				if (full) status = ST_FULL;
				else cmd.do_dispatch = acc;
			end
			REQ_WAKEUP: cmd.do_wakeup = acc;
			REQ_SELECT: begin
				cmd.do_select = acc;
				if (!hit) status = ST_NONE;
			end
			REQ_REMOVE: begin
				if ({{(32-IDX_BITS){1'b0}}, idx} >= 32'(count)) status = ST_BAD_IDX;
				else cmd.do_remove = acc;
			end
			default: status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.do_remove |-> count != '0)
		else $error("remove on empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.do_dispatch |-> !full)
		else $error("dispatch into full queue");
endmodule

/* rtl/core/issue_queue_wakeup_select.sv */
// Top level of the collapsing issue queue with wakeup and oldest-ready select.
// Depends on iqws_pkg, iqws_stream_if, iqws_ctrl and iqws_datapath.
//
// Usage: each request transaction on req (dispatch, wakeup, select, remove)
// yields exactly one result transaction on rsp. A request is accepted when
// req.valid and req.ready are both high. The request is applied to the entry
// registers at that edge and its result is loaded into the output register,
// visible in the next cycle. Throughput is one request per cycle unless rsp
// stalls, set by the combinational select priority chain and collapse shift
// over all entries. While a result waits on a stalled receiver, req.ready
// drops; when rsp.ready is high, a new request is taken in the same cycle the
// held result leaves. Reset clears the occupancy count and the result valid
// flag; entry contents are don't-care until dispatched. Wakeup compares the
// broadcast tag (a_tag) against both source tags of every live entry.
// picked_* fields are zero unless a select finds an entry.
module issue_queue_wakeup_select (
	input logic  clk,
	input logic  arst_n,
	iqws_stream_if.sink   req,
	iqws_stream_if.source rsp
);
	import iqws_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(IQ_DEPTH + 1);
	localparam int unsigned IW       = $clog2(IQ_DEPTH);

	iqws_cmd_t              cmd;
	status_t                status;
	logic                   load, hit, pick;
	logic [CNT_BITS-1:0]    count;
	logic [CNT_BITS-1:0]    count_nxt;
	logic [IW-1:0]          hit_idx;
	logic [31:0]            hit_lit, hit_av, hit_bv;
	logic [IQ_TAG_BITS-1:0] hit_dest;

	iqws_ctrl #(.QUEUE_DEPTH(IQ_DEPTH)) u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.req(req_t'(req.data.req_type)), .idx(req.data.slot_index),
		.count, .hit, .cmd, .status, .load,
		.out_valid(rsp.valid), .out_ready(rsp.ready)
	);

	iqws_datapath #(.QUEUE_DEPTH(IQ_DEPTH), .TAG_BITS(IQ_TAG_BITS)) u_dp (
		.clk, .arst_n, .cmd,
		.rm_idx(req.data.slot_index[IW-1:0]),
		.in_en(req.data.issue_enable), .in_unit(req.data.unit_type),
		.in_lit(req.data.literal_value),
		.in_ar(req.data.a_ready), .in_at(req.data.a_tag),
		.in_av(req.data.a_value),
		.in_br(req.data.b_ready), .in_bt(req.data.b_tag),
		.in_bv(req.data.b_value), .in_dest(req.data.dest_tag),
		.count, .hit, .hit_idx, .hit_lit, .hit_av, .hit_bv, .hit_dest
	);

	assign pick = cmd.do_select && hit;

	always_comb begin
		count_nxt = count;
		if (cmd.do_dispatch) count_nxt = count + CNT_BITS'(1);
		else if (cmd.do_remove) count_nxt = count - CNT_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp.data.status_code    <= status;
			rsp.data.picked_index   <= pick ? IDX_BITS'(hit_idx) : '0;
			rsp.data.picked_literal <= pick ? hit_lit : '0;
			rsp.data.picked_a_value <= pick ? hit_av : '0;
			rsp.data.picked_b_value <= pick ? hit_bv : '0;
			rsp.data.picked_dest    <= pick ? hit_dest : '0;
			rsp.data.occupancy      <= IDX_BITS'(count_nxt);
			rsp.data.queue_empty    <= count_nxt == '0;
			rsp.data.queue_full     <= count_nxt == CNT_BITS'(IQ_DEPTH);
		end
	end
endmodule

/* test/tb_issue_queue_wakeup_select.sv */
// Testbench for issue_queue_wakeup_select: directed and random requests checked
// against an in-bench prediction of the collapsing queue, with random stalls.
// Depends on iqws_pkg, iqws_stream_if and the issue_queue_wakeup_select RTL.
module tb_issue_queue_wakeup_select;
	timeunit 1ns;
	timeprecision 1ps;
	import iqws_pkg::*;

	localparam int DEPTH = 12;

	typedef iqws_req_t iq_req_t;
	typedef iqws_rsp_t iq_rsp_t;

	typedef struct {
		logic        en;
		logic [2:0]  unit;
		logic [31:0] lit;
		logic        ardy;
		logic [5:0]  atag;
		logic [31:0] aval;
		logic        brdy;
		logic [5:0]  btag;
		logic [31:0] bval;
		logic [5:0]  dest;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iqws_stream_if #(.payload_t(iq_req_t)) req_if (clk);
	iqws_stream_if #(.payload_t(iq_rsp_t)) rsp_if (clk);

	issue_queue_wakeup_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	slot_t   iq_slots [DEPTH];
	int      iq_live;
	iq_req_t pending_reqs[$];
	iq_rsp_t expected_rsps[$];
	int      n_accepted;
	int      n_errors;
	bit      req_taken;

	function automatic iq_rsp_t predict_request(iq_req_t r);
		iq_rsp_t o;
		o = '0;
		o.status_code = ST_OK;
		case (r.req_type)
			REQ_DISPATCH: begin
				if (iq_live >= DEPTH) begin
					o.status_code = ST_FULL;
				end else begin
					iq_slots[iq_live] = '{r.issue_enable, r.unit_type, r.literal_value,
						r.a_ready, r.a_tag, r.a_value, r.b_ready, r.b_tag, r.b_value,
						r.dest_tag};
					iq_live++;
				end
			end
			REQ_WAKEUP: begin
				for (int i = 0; i < iq_live; i++) begin
					if (iq_slots[i].atag == r.a_tag) begin
						iq_slots[i].ardy = 1'b1;
						iq_slots[i].aval = r.a_value;
					end
					if (iq_slots[i].btag == r.a_tag) begin
						iq_slots[i].brdy = 1'b1;
						iq_slots[i].bval = r.a_value;
					end
				end
			end
			REQ_SELECT: begin
				o.status_code = ST_NONE;
				for (int i = 0; i < iq_live; i++) begin
					if (iq_slots[i].unit == r.unit_type && iq_slots[i].en &&
							iq_slots[i].ardy && iq_slots[i].brdy) begin
						o.status_code = ST_OK;
						o.picked_index = i[3:0];
						o.picked_literal = iq_slots[i].lit;
						o.picked_a_value = iq_slots[i].aval;
						o.picked_b_value = iq_slots[i].bval;
						o.picked_dest = iq_slots[i].dest;
						break;
					end
				end
			end
			default: begin
				if (r.slot_index >= iq_live) begin
					o.status_code = ST_BAD_IDX;
				end else begin
					for (int i = r.slot_index; i + 1 < iq_live; i++)
						iq_slots[i] = iq_slots[i + 1];
					iq_live--;
				end
			end
		endcase
		o.occupancy = iq_live[3:0];
		o.queue_empty = (iq_live == 0);
		o.queue_full = (iq_live == DEPTH);
		return o;
	endfunction

	function automatic iq_req_t make_dispatch(int tag_span);
		iq_req_t r;
		r = '0;
		r.req_type = REQ_DISPATCH;
		r.slot_index = 4'($urandom_range(15));
		r.issue_enable = ($urandom_range(9) != 0);
		r.unit_type = 3'($urandom_range(3));
		if ($urandom_range(7) == 0)
			r.unit_type = 3'($urandom_range(7));
		r.literal_value = $urandom;
		r.a_ready = 1'($urandom_range(1));
		r.a_tag = 6'($urandom_range(tag_span));
		r.a_value = $urandom;
		r.b_ready = 1'($urandom_range(1));
		r.b_tag = 6'($urandom_range(tag_span));
		r.b_value = $urandom;
		r.dest_tag = 6'($urandom_range(63));
		return r;
	endfunction

	function automatic iq_req_t make_random_request();
		iq_req_t r;
		int      pick;
		int      span;
		span = ($urandom_range(9) == 0) ? 63 : 7;
		r = make_dispatch(span);
		pick = $urandom_range(99);
		if (pick < 35)
			r.req_type = REQ_DISPATCH;
		else if (pick < 60)
			r.req_type = REQ_WAKEUP;
		else if (pick < 82)
			r.req_type = REQ_SELECT;
		else
			r.req_type = REQ_REMOVE;
		if (r.req_type == REQ_REMOVE && $urandom_range(4) != 0)
			r.slot_index = 4'($urandom_range(DEPTH - 1));
		return r;
	endfunction

	function automatic int sender_idle_pct();
		if (n_accepted < 300)
			return 28;
		if (n_accepted < 600)
			return 59;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_accepted < 300)
			return 59;
		if (n_accepted < 600)
			return 28;
		return 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
			if (!req_if.valid || req_taken) begin
				req_taken = 1'b0;
				if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
					req_if.valid <= 1'b1;
					req_if.data <= pending_reqs.pop_front();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (req_if.valid && req_if.ready) begin
			expected_rsps = {expected_rsps, predict_request(req_if.data)};
			req_taken = 1'b1;
			n_accepted++;
		end
	end

	task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $realtime, fname, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		iq_rsp_t e;
		iq_rsp_t a;
		if (rsp_if.valid && rsp_if.ready) begin
			a = rsp_if.data;
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result transaction %h", $realtime, a);
				n_errors++;
			end else begin
				e = expected_rsps.pop_front();
				check_field("status_code", e.status_code, a.status_code);
				check_field("picked_index", e.picked_index, a.picked_index);
				check_field("picked_literal", e.picked_literal, a.picked_literal);
				check_field("picked_a_value", e.picked_a_value, a.picked_a_value);
				check_field("picked_b_value", e.picked_b_value, a.picked_b_value);
				check_field("picked_dest", e.picked_dest, a.picked_dest);
				check_field("occupancy", e.occupancy, a.occupancy);
				check_field("queue_empty", e.queue_empty, a.queue_empty);
				check_field("queue_full", e.queue_full, a.queue_full);
			end
		end
	end

	initial begin
		iq_req_t r;
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		iq_live = 0;
		n_accepted = 0;
		n_errors = 0;
		req_taken = 1'b0;

		r = '0;
		r.req_type = REQ_SELECT;
		pending_reqs = {pending_reqs, r};
		r.req_type = REQ_REMOVE;
		pending_reqs = {pending_reqs, r};
		for (int i = 0; i < DEPTH; i++) begin
			r = make_dispatch(7);
			r.unit_type = 3'(i % 8);
			r.issue_enable = 1'b1;
			if (i == 0) begin
				r.literal_value = 32'h8000_0000;
				r.a_value = 32'h7FFF_FFFF;
				r.b_value = 32'hFFFF_FFFF;
				r.a_tag = 6'd63;
				r.b_tag = 6'd0;
				r.dest_tag = 6'd63;
				r.a_ready = 1'b0;
				r.b_ready = 1'b0;
			end
			pending_reqs = {pending_reqs, r};
		end
		r = make_dispatch(63);
		pending_reqs = {pending_reqs, r};
		r.req_type = REQ_SELECT;
		r.unit_type = 3'd0;
		pending_reqs = {pending_reqs, r};
		r.req_type = REQ_WAKEUP;
		r.a_tag = 6'd63;
		r.a_value = 32'h8000_0000;
		pending_reqs = {pending_reqs, r};
		r.a_tag = 6'd0;
		r.a_value = 32'h7FFF_FFFF;
		pending_reqs = {pending_reqs, r};
		r.req_type = REQ_SELECT;
		r.unit_type = 3'd0;
		pending_reqs = {pending_reqs, r};
		r.unit_type = 3'd7;
		pending_reqs = {pending_reqs, r};
		r.req_type = REQ_REMOVE;
		r.slot_index = 4'd12;
		pending_reqs = {pending_reqs, r};
		r.slot_index = 4'd15;
		pending_reqs = {pending_reqs, r};
		r.slot_index = 4'd11;
		pending_reqs = {pending_reqs, r};
		r.slot_index = 4'd0;
		pending_reqs = {pending_reqs, r};
		for (int i = 0; i < 830; i++)
			pending_reqs = {pending_reqs, make_random_request()};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("issue_queue_wakeup_select verification clean");
		else
			$display("issue_queue_wakeup_select verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("issue_queue_wakeup_select verification failed");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/iqws_pkg.sv
rtl/core/iqws_stream_if.sv
rtl/core/iqws_datapath.sv
rtl/core/iqws_ctrl.sv
rtl/core/issue_queue_wakeup_select.sv
test/tb_issue_queue_wakeup_select.sv
